// ===== rtl/bqsr_pkg.sv =====
// Shared types and constants for the byte queue with search and remove.
package bqsr_pkg;

    localparam int DATA_W        = 8;
    localparam int OPC_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 16;
    localparam int DEPTH_DEFAULT = 16;
    localparam int CMDQ_DEPTH    = 2;

    // Operation codes as carried on the input stream
    typedef enum logic [OPC_W-1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t               kind;
        logic [DATA_W-1:0] data;
    } cmd_t;

endpackage

// ===== rtl/byte_queue_search_remove.sv =====
// Top level of the byte queue with search and remove.
//
// Input stream (s_*): one operation per transaction. s_tdata carries the
// opcode in bits [1:0] (append, remove from head, find and remove) and the
// byte in bits [9:2]. Output stream (m_*): exactly one result per operation,
// in order. m_tdata carries the removed byte, status, empty flag and the
// occupancy after the operation.
// Append, no-op and any operation on an empty queue complete in the idle
// state; a remove first reads the head entry; a find scans up to the match,
// then compacts the rest, one memory entry per cycle on the single read and
// write port.
// Append and no-op sustain one transaction per cycle while the results are
// taken; a remove or a find keeps the execution unit busy until it is done.
// A two-entry command buffer lets the input side keep accepting while the
// execution unit is busy. When m_tready is low the result register holds and
// execution stops at the next command; the input side stalls once the buffer
// fills. Reset empties the queue and both buffers; stored bytes are not
// cleared and their values are never used before they are written.
module byte_queue_search_remove #(
    parameter int DEPTH = bqsr_pkg::DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: opcode[1:0], data_in[9:2], zero[15:10]
    input  logic [bqsr_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: data_out[7:0], status[9:8], is_empty[10], occupancy[15:11]
    output logic [bqsr_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic            cmd_valid;
    bqsr_pkg::cmd_t  cmd;
    logic            cmd_pop;

    bqsr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    bqsr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Command taken only when one is buffered
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty buffer");

    // Empty status comes with an empty queue and a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9:8] == bqsr_pkg::ST_EMPTY) |->
        (m_tdata[10] && m_tdata[7:0] == 8'd0))
        else $error("empty status with data or entries");

    // Empty flag agrees with occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && DEPTH < 32) |-> (m_tdata[10] == (m_tdata[15:11] == 5'd0)))
        else $error("empty flag disagrees with occupancy");

    // Dropped append only when the queue is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && DEPTH < 32 && m_tdata[9:8] == bqsr_pkg::ST_FULL) |->
        (m_tdata[15:11] == bqsr_pkg::OCC_W'(DEPTH)))
        else $error("full status below capacity");

endmodule

// ===== rtl/bqsr_front.sv =====
// Front end: accepts input transactions, classifies them, and buffers commands.
module bqsr_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bqsr_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            cmd_valid,
    output bqsr_pkg::cmd_t                  cmd,
    input  logic                            cmd_pop
);

    localparam int QD = bqsr_pkg::CMDQ_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int NW = $clog2(QD + 1);

    bqsr_pkg::cmd_t       queue_reg [QD];
    logic [PW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]        fill_reg, fill_next;
    bqsr_pkg::cmd_t       cls_cmd;
    logic                 push;
    logic                 pop;

    // Classify the incoming opcode
    always_comb begin
        cls_cmd.data = s_tdata[bqsr_pkg::OPC_W +: bqsr_pkg::DATA_W];
        case (s_tdata[bqsr_pkg::OPC_W-1:0])
            bqsr_pkg::OP_APPEND: cls_cmd.kind = bqsr_pkg::OP_APPEND;
            bqsr_pkg::OP_REMOVE: cls_cmd.kind = bqsr_pkg::OP_REMOVE;
            bqsr_pkg::OP_FIND:   cls_cmd.kind = bqsr_pkg::OP_FIND;
            default:             cls_cmd.kind = bqsr_pkg::OP_NOP;
        endcase
    end

    assign s_tready  = (fill_reg != NW'(QD));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_pop && cmd_valid;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the classified command
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

// ===== rtl/bqsr_back.sv =====
// Back end: executes queue commands on the entry memory and drives the result register.
module bqsr_back #(
    parameter int DEPTH = bqsr_pkg::DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    input  bqsr_pkg::cmd_t                  cmd,
    output logic                            cmd_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bqsr_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = bqsr_pkg::DATA_W;
    localparam int OW = bqsr_pkg::OCC_W;
    localparam logic [AW:0] DEPTH_A = (AW + 1)'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_SHIFT = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [DW-1:0]        key_reg, key_next;

    logic [DW-1:0]        mem [DEPTH];
    logic [DW-1:0]        rdata_reg;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [DW-1:0]        wdata;
    logic                 mem_we;

    logic                 res_load;
    logic [DW-1:0]        res_data;
    bqsr_pkg::status_t    res_status;
    logic [CW+OW-1:0]     cnt_ext;

    logic                 m_tvalid_reg;
    logic [DW-1:0]        m_data_reg;
    bqsr_pkg::status_t    m_status_reg;
    logic                 m_empty_reg;
    logic [OW-1:0]        m_occ_reg;

    logic                 out_free;
    logic                 is_full;
    logic                 is_last;
    logic                 shift_last;

    // Circular index: base plus offset, offset at most DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW:0] offs);
        logic [AW:0] sum;
        sum = {1'b0, base} + offs;
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    assign out_free   = !m_tvalid_reg || m_tready;
    assign is_full    = (count_reg == CW'(DEPTH));
    assign is_last    = ((CW'(pos_reg) + 1'b1) == count_reg);
    assign shift_last = ((CW'(pos_reg) + CW'(2)) == count_reg);

    // Sequence one command: completed in idle, a head read, or a scan with compaction after a match
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        mem_we     = 1'b0;
        waddr      = wrap_add(head_reg, {1'b0, count_reg[AW-1:0]});
        wdata      = cmd.data;
        raddr      = head_reg;
        res_load   = 1'b0;
        res_data   = '0;
        res_status = bqsr_pkg::ST_OK;
        cmd_pop    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        bqsr_pkg::OP_APPEND: begin
                            res_load = 1'b1;
                            if (is_full) begin
                                res_status = bqsr_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bqsr_pkg::OP_REMOVE: begin
                            if (count_reg == '0) begin
                                res_load   = 1'b1;
                                res_status = bqsr_pkg::ST_EMPTY;
                            end else begin
                                state_next = S_READ;
                            end
                        end
                        bqsr_pkg::OP_FIND: begin
                            key_next = cmd.data;
                            pos_next = '0;
                            if (count_reg == '0) begin
                                res_load   = 1'b1;
                                res_status = bqsr_pkg::ST_NOT_FOUND;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                res_load   = 1'b1;
                res_data   = rdata_reg;
                head_next  = wrap_add(head_reg, (AW + 1)'(1));
                count_next = count_reg - 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN: begin
                // Read the next entry while checking the current one
                raddr = wrap_add(head_reg, {1'b0, pos_reg} + 1'b1);
                if (rdata_reg == key_reg) begin
                    if (is_last) begin
                        res_load   = 1'b1;
                        count_next = count_reg - 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_SHIFT;
                    end
                end else if (is_last) begin
                    res_load   = 1'b1;
                    res_status = bqsr_pkg::ST_NOT_FOUND;
                    state_next = S_IDLE;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_SHIFT: begin
                // Move the entry after pos down into pos
                mem_we = 1'b1;
                waddr  = wrap_add(head_reg, {1'b0, pos_reg});
                wdata  = rdata_reg;
                raddr  = wrap_add(head_reg, {1'b0, pos_reg} + (AW + 1)'(2));
                if (shift_last) begin
                    res_load   = 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        key_reg <= key_next;
    end

    // Entry memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Hold the result until the receiver takes it
    assign cnt_ext = {{OW{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg   <= res_data;
            m_status_reg <= res_status;
            m_empty_reg  <= (count_next == '0);
            m_occ_reg    <= cnt_ext[OW-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_occ_reg, m_empty_reg, m_status_reg, m_data_reg};

endmodule

// ===== dv/tb_byte_queue_search_remove.sv =====
// Self-checking testbench for the byte queue with search and remove.
`timescale 1ns / 1ps

module tb_byte_queue_search_remove;
    import bqsr_pkg::*;

    localparam int QDEPTH      = DEPTH_DEFAULT;
    localparam int RAND_ITEMS  = 650;
    localparam int NUM_PHASES  = 4;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 3 * (QDEPTH + 2);

    // One result as carried on m_tdata
    typedef struct {
        logic [DATA_W-1:0] data_out;
        status_t           status;
        logic              is_empty;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

    // One row of the directed stimulus table
    typedef struct {
        op_t               op;
        logic [DATA_W-1:0] data;
        bit                typed;
        result_t           want;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the queue contents, head at index 0
    logic [DATA_W-1:0] held_bytes[$];
    // Results still owed by the block, oldest first
    result_t           pending_results[$];
    dir_row_t          dir_tab[$];

    int fail_cnt;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    byte_queue_search_remove #(
        .DEPTH(QDEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Generate a 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one operation to the shadow queue and return the result it yields
    function automatic result_t apply_queue_op(op_t op, logic [DATA_W-1:0] b);
        result_t r;
        r.data_out = '0;
        r.status   = ST_OK;
        case (op)
            OP_APPEND: begin
                if (held_bytes.size() >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_bytes.push_back(b);
                end
            end
            OP_REMOVE: begin
                if (held_bytes.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = held_bytes.pop_front();
                end
            end
            OP_FIND: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < held_bytes.size(); i++) begin
                    if (held_bytes[i] == b) begin
                        held_bytes.delete(i);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.is_empty  = (held_bytes.size() == 0);
        r.occupancy = OCC_W'(held_bytes.size());
        return r;
    endfunction

    function automatic dir_row_t mk_row(op_t op, logic [DATA_W-1:0] b, int typed,
                                        logic [DATA_W-1:0] dout, status_t st,
                                        int emp, int occ);
        dir_row_t row;
        row.op              = op;
        row.data            = b;
        row.typed           = (typed != 0);
        row.want.data_out   = dout;
        row.want.status     = st;
        row.want.is_empty   = (emp != 0);
        row.want.occupancy  = OCC_W'(occ);
        return row;
    endfunction

    // Offer one transaction, honoring the current sender idle rate
    task automatic send_op(op_t op, logic [DATA_W-1:0] b, bit typed, result_t want);
        result_t got;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - OPC_W - DATA_W){1'b0}}, b, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = apply_queue_op(op, b);
        pending_results.push_back(typed ? want : got);
    endtask

    // Pick a random operation, steered by whether the queue is filling or draining
    task automatic send_random_op(bit filling);
        int      pick;
        op_t     op;
        logic [DATA_W-1:0] b;
        result_t none;
        none.data_out  = '0;
        none.status    = ST_OK;
        none.is_empty  = 1'b0;
        none.occupancy = '0;
        pick = $urandom_range(99);
        if (filling) begin
            op = (pick < 55) ? OP_APPEND : (pick < 70) ? OP_REMOVE :
                 (pick < 95) ? OP_FIND : OP_NOP;
        end else begin
            op = (pick < 20) ? OP_APPEND : (pick < 55) ? OP_REMOVE :
                 (pick < 92) ? OP_FIND : OP_NOP;
        end
        // Favor bytes already held so that finds hit, and a tiny alphabet for duplicates
        if (op == OP_FIND && held_bytes.size() != 0 && $urandom_range(3) != 0) begin
            b = held_bytes[$urandom_range(held_bytes.size() - 1)];
        end else if ($urandom_range(3) == 0) begin
            b = DATA_W'($urandom_range(3));
        end else begin
            b = DATA_W'($urandom_range(255));
        end
        send_op(op, b, 1'b0, none);
    endtask

    // Stall the result side at random and check every result transaction
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual m_tdata=%h", $time, m_tdata);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.data_out) begin
                    $display("%0t: data_out mismatch, expected %h actual %h",
                             $time, want.data_out, m_tdata[7:0]);
                    fail_cnt++;
                end
                if (m_tdata[9:8] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, m_tdata[9:8]);
                    fail_cnt++;
                end
                if (m_tdata[10] !== want.is_empty) begin
                    $display("%0t: is_empty mismatch, expected %b actual %b",
                             $time, want.is_empty, m_tdata[10]);
                    fail_cnt++;
                end
                if (m_tdata[15:11] !== want.occupancy) begin
                    $display("%0t: occupancy mismatch, expected %0d actual %0d",
                             $time, want.occupancy, m_tdata[15:11]);
                    fail_cnt++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed table, then random phases
    initial begin
        int  left;
        int  per_phase;
        bit  filling;
        int  run_left;
        idle_pct     = 0;
        stall_pct    = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;

        // Directed rows; expectations typed in only where obvious
        dir_tab.push_back(mk_row(OP_REMOVE, 8'h00, 1, 8'h00, ST_EMPTY,     1, 0));
        dir_tab.push_back(mk_row(OP_FIND,   8'h5a, 1, 8'h00, ST_NOT_FOUND, 1, 0));
        dir_tab.push_back(mk_row(OP_NOP,    8'hff, 1, 8'h00, ST_OK,        1, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'h00, 1, 8'h00, ST_OK,        0, 1));
        dir_tab.push_back(mk_row(OP_APPEND, 8'hff, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'h80, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'h7f, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'h55, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'haa, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'h01, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'hfe, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'h33, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'hcc, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'h0f, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'hf0, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'h5a, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'ha5, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'h3c, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_APPEND, 8'hc3, 0, 8'h00, ST_OK, 0, 0));
        // Full queue drops the byte
        dir_tab.push_back(mk_row(OP_APPEND, 8'h99, 1, 8'h00, ST_FULL, 0, 16));
        // Match on the tail entry, then in the middle, then no match
        dir_tab.push_back(mk_row(OP_FIND,   8'hc3, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_FIND,   8'h55, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_FIND,   8'h12, 0, 8'h00, ST_OK, 0, 0));
        // Tail must follow the last kept entry after a find
        dir_tab.push_back(mk_row(OP_APPEND, 8'h12, 0, 8'h00, ST_OK, 0, 0));
        dir_tab.push_back(mk_row(OP_REMOVE, 8'h00, 0, 8'h00, ST_OK, 0, 0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table with no idling
        foreach (dir_tab[i]) begin
            send_op(dir_tab[i].op, dir_tab[i].data, dir_tab[i].typed, dir_tab[i].want);
        end

        // Random phases; between phases hold off until every result has come
        left      = RAND_ITEMS;
        per_phase = RAND_ITEMS / NUM_PHASES;
        filling   = 1'b1;
        run_left  = $urandom_range(20, 60);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            for (int n = 0; n < ((ph == NUM_PHASES - 1) ? left : per_phase); n++) begin
                send_random_op(filling);
                run_left--;
                if (run_left == 0) begin
                    filling  = !filling;
                    run_left = $urandom_range(20, 60);
                end
            end
            left -= per_phase;
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge aclk);
        end

        // Let any stray result surface before the verdict
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== byte_queue_search_remove.f =====
rtl/bqsr_pkg.sv
rtl/bqsr_front.sv
rtl/bqsr_back.sv
rtl/byte_queue_search_remove.sv
dv/tb_byte_queue_search_remove.sv
